[sv/psvu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvu_pkg
// Shared types, widths, codes and helpers for the particle velocity update.
// ----------------------------------------------------------------------------
package psvu_pkg;

    localparam int CoordWidth = 24;
    localparam int DimMaxDefault = 64;
    localparam int IndexW = 6;
    localparam int DimsW = 7;
    localparam int DimsMax = 127;
    localparam int CoefW = 16;
    localparam int FracW = 16;
    localparam int SumW = 31;
    localparam int MeanW = 24;
    localparam int CfgIndexW = 2;
    localparam int CfgDataW = 16;

    localparam int MulAW = 33;
    localparam int MulBW = 32;
    localparam int ProdW = MulAW + MulBW + 1;
    localparam int TermW = 30;
    localparam int AccW = 32;
    localparam int SatInW = 56;
    localparam int PullShift = 28;
    localparam int InertiaShift = 12;

    localparam logic [CoefW-1:0] InertiaReset = 16'd4096;
    localparam logic [CoefW-1:0] PullReset = 16'd4096;
    localparam logic [DimsW-1:0] DimsReset = 7'd64;

    localparam logic [CfgIndexW-1:0] CfgInertia = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgPullGlobal = 2'd1;
    localparam logic [CfgIndexW-1:0] CfgPullLocal = 2'd2;
    localparam logic [CfgIndexW-1:0] CfgDims = 2'd3;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_VEL  = 2'd1,
        REQ_POS  = 2'd2,
        REQ_READ = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic pos_we;
        logic vel_we;
        logic pb_we;
    } store_wr_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic signed [CoordWidth-1:0] sat_coord(
        input logic signed [SatInW-1:0] v
    );
        logic signed [CoordWidth-1:0] lo_part;
        logic signed [SatInW-1:0]     back;
        lo_part = v[CoordWidth-1:0];
        back = SatInW'(lo_part);
        if (back == v)
            return lo_part;
        else if (v[SatInW-1])
            return {1'b1, {(CoordWidth-1){1'b0}}};
        else
            return {1'b0, {(CoordWidth-1){1'b1}}};
    endfunction

endpackage

[sv/psvu_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvu_req_if
// Request channel: valid/ready handshake with one coordinate request.
// ----------------------------------------------------------------------------
interface psvu_req_if
    import psvu_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [IndexW-1:0]            elem_index;
    logic signed [CoordWidth-1:0] coord_value;
    logic signed [CoordWidth-1:0] vel_value;
    logic [FracW-1:0]             rand_global;
    logic [FracW-1:0]             rand_local;

    modport source (
        output valid, req_type, elem_index, coord_value, vel_value,
               rand_global, rand_local,
        input  ready
    );

    modport sink (
        input  valid, req_type, elem_index, coord_value, vel_value,
               rand_global, rand_local,
        output ready
    );
endinterface

[sv/psvu_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvu_rsp_if
// Response channel: valid/ready handshake with one result.
// ----------------------------------------------------------------------------
interface psvu_rsp_if
    import psvu_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [CoordWidth-1:0] result_value;
    logic [MeanW-1:0]             mean_change;
    logic                         mean_valid;
    logic                         index_ok;

    modport source (
        output valid, result_value, mean_change, mean_valid, index_ok,
        input  ready
    );

    modport sink (
        input  valid, result_value, mean_change, mean_valid, index_ok,
        output ready
    );
endinterface

[sv/particle_swarm_velocity_update.sv]
`timescale 1ns / 1ps
// A request passes through the sequencer states: an out-of-range index goes
// straight to DONE, a load through LD, a read or position update through RD and
// M1, a velocity update through RD, M1 to M5, WB and CH, and through DIV when it
// closes a sweep. One request at a time; a waiting result holds the sequencer in
// DONE. Reset restores the register defaults and clears the change sum; the
// coordinate memories are not initialised.
// ----------------------------------------------------------------------------
// particle_swarm_velocity_update
// Sequencer around a shared multiplier, coordinate memories and a divider.
// ----------------------------------------------------------------------------
module particle_swarm_velocity_update
    import psvu_pkg::*;
#(
    parameter int DIM_MAX = DimMaxDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    psvu_req_if.sink             req,
    psvu_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    localparam int AddrW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DimCapInt = (DIM_MAX > DimsMax) ? DimsMax : DIM_MAX;
    localparam logic [DimsW-1:0] DimCap = DimsW'(DimCapInt);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_LD   = 12'b0000_0000_0010,
        ST_RD   = 12'b0000_0000_0100,
        ST_M1   = 12'b0000_0000_1000,
        ST_M2   = 12'b0000_0001_0000,
        ST_M3   = 12'b0000_0010_0000,
        ST_M4   = 12'b0000_0100_0000,
        ST_M5   = 12'b0000_1000_0000,
        ST_WB   = 12'b0001_0000_0000,
        ST_CH   = 12'b0010_0000_0000,
        ST_DIV  = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CoefW-1:0] inertia_reg, pull_global_reg, pull_local_reg;
    logic [DimsW-1:0] dims_reg;
    logic [DimsW-1:0] lim;
    logic             in_range;
    logic             accept;

    req_kind_t                    kind_reg;
    logic [IndexW-1:0]            idx_reg;
    logic signed [CoordWidth-1:0] cv_reg, vv_reg;
    logic [FracW-1:0]             r1_reg, r2_reg;
    logic                         ok_reg, last_reg;

    logic [MulBW-1:0]             rc1_reg, rc2_reg;
    logic signed [TermW-1:0]      t1_reg;
    logic signed [AccW-1:0]       acc_reg;
    logic signed [CoordWidth-1:0] nv_reg;
    logic signed [CoordWidth-1:0] res_reg;
    logic [MeanW-1:0]             mean_reg;
    logic                         mvalid_reg;
    logic [SumW-1:0]              sum_reg;

    logic                         out_valid_reg;
    logic signed [CoordWidth-1:0] out_res_reg;
    logic [MeanW-1:0]             out_mean_reg;
    logic                         out_mvalid_reg, out_ok_reg;

    logic signed [MulAW-1:0]      mul_a;
    logic [MulBW-1:0]             mul_b;
    logic signed [ProdW-1:0]      prod_reg;

    store_wr_t                    wr;
    logic signed [CoordWidth-1:0] pos_wdata, vel_wdata;
    logic signed [CoordWidth-1:0] x_rd, v_rd, pb_rd;

    logic signed [TermW-1:0]      t2;
    logic signed [CoordWidth-1:0] pos_new;
    logic signed [CoordWidth:0]   vdiff;
    logic [CoordWidth:0]          vabs;
    logic [SumW:0]                sum_wide;
    logic [SumW-1:0]              sum_new;

    div_stat_t                    div_stat;
    logic [SumW-1:0]              quotient;
    logic                         div_start;
    logic                         out_free;

    assign lim = (dims_reg < DimCap) ? dims_reg : DimCap;
    assign in_range = {1'b0, req.elem_index} < lim;
    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_reg     <= InertiaReset;
            pull_global_reg <= PullReset;
            pull_local_reg  <= PullReset;
            dims_reg        <= DimsReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgInertia:    inertia_reg <= cfg_data;
                CfgPullGlobal: pull_global_reg <= cfg_data;
                CfgPullLocal:  pull_local_reg <= cfg_data;
                CfgDims:       dims_reg <= cfg_data[DimsW-1:0];
                default:       dims_reg <= dims_reg;
            endcase
        end
    end

    psvu_store #(
        .DIM_MAX (DIM_MAX),
        .AddrW   (AddrW)
    ) u_store (
        .clk       (clk),
        .addr      (AddrW'(idx_reg)),
        .wr        (wr),
        .pos_wdata (pos_wdata),
        .vel_wdata (vel_wdata),
        .pos_rd    (x_rd),
        .vel_rd    (v_rd),
        .pb_rd     (pb_rd)
    );

    psvu_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    assign div_start = (state_reg == ST_CH) && last_reg;

    psvu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_new),
        .divisor  (lim),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RD:
            begin
                mul_a = MulAW'(r1_reg);
                mul_b = MulBW'(pull_global_reg);
            end
            ST_M1:
            begin
                mul_a = MulAW'(r2_reg);
                mul_b = MulBW'(pull_local_reg);
            end
            ST_M2:
            begin
                mul_a = MulAW'(cv_reg) - MulAW'(x_rd);
                mul_b = rc1_reg;
            end
            ST_M3:
            begin
                mul_a = MulAW'(pb_rd) - MulAW'(x_rd);
                mul_b = rc2_reg;
            end
            ST_M5:
            begin
                mul_a = MulAW'(acc_reg);
                mul_b = MulBW'(inertia_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign t2 = TermW'(prod_reg >>> PullShift);
    assign pos_new = sat_coord(SatInW'(x_rd) + SatInW'(v_rd));
    assign vdiff = (CoordWidth+1)'(v_rd) - (CoordWidth+1)'(nv_reg);
    assign vabs = vdiff[CoordWidth] ? (CoordWidth+1)'(-vdiff) : (CoordWidth+1)'(vdiff);
    assign sum_wide = {1'b0, sum_reg} + (SumW+1)'(vabs);
    assign sum_new = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];

    // memory writes
    always_comb
    begin
        wr = '0;
        pos_wdata = pos_new;
        vel_wdata = nv_reg;
        case (state_reg)
            ST_LD:
            begin
                wr.pos_we = 1'b1;
                wr.pb_we  = 1'b1;
                wr.vel_we = 1'b1;
                pos_wdata = sat_coord(SatInW'(cv_reg));
                vel_wdata = sat_coord(SatInW'(vv_reg));
            end
            ST_M1:
                wr.pos_we = (kind_reg == REQ_POS);
            ST_CH:
                wr.vel_we = 1'b1;
            default:
                wr = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (!in_range)
                        state_next = ST_DONE;
                    else if (req_kind_t'(req.req_type) == REQ_LOAD)
                        state_next = ST_LD;
                    else
                        state_next = ST_RD;
                end
            ST_LD:   state_next = ST_DONE;
            ST_RD:   state_next = ST_M1;
            ST_M1:   state_next = (kind_reg == REQ_VEL) ? ST_M2 : ST_DONE;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_M5;
            ST_M5:   state_next = ST_WB;
            ST_WB:   state_next = ST_CH;
            ST_CH:   state_next = last_reg ? ST_DIV : ST_DONE;
            ST_DIV:  state_next = div_stat.done ? ST_DONE : ST_DIV;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CH)
                sum_reg <= last_reg ? '0 : sum_new;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= req_kind_t'(req.req_type);
            idx_reg    <= req.elem_index;
            cv_reg     <= req.coord_value;
            vv_reg     <= req.vel_value;
            r1_reg     <= req.rand_global;
            r2_reg     <= req.rand_local;
            ok_reg     <= in_range;
            last_reg   <= {1'b0, req.elem_index} == (lim - 1'b1);
            res_reg    <= '0;
            mean_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        case (state_reg)
            ST_M1:
            begin
                rc1_reg <= prod_reg[MulBW-1:0];
                if (kind_reg == REQ_POS)
                    res_reg <= pos_new;
                else if (kind_reg == REQ_READ)
                    res_reg <= x_rd;
            end
            ST_M2: rc2_reg <= prod_reg[MulBW-1:0];
            ST_M3: t1_reg <= TermW'(prod_reg >>> PullShift);
            ST_M4: acc_reg <= AccW'(v_rd) + AccW'(t1_reg) + AccW'(t2);
            ST_WB: nv_reg <= sat_coord(SatInW'(prod_reg >>> InertiaShift));
            ST_CH: res_reg <= nv_reg;
            ST_DIV:
                if (div_stat.done)
                begin
                    mean_reg   <= (|quotient[SumW-1:MeanW]) ? {MeanW{1'b1}}
                                                            : quotient[MeanW-1:0];
                    mvalid_reg <= 1'b1;
                end
            default: ;
        endcase
        if (state_reg == ST_DONE && out_free)
        begin
            out_res_reg    <= res_reg;
            out_mean_reg   <= mean_reg;
            out_mvalid_reg <= mvalid_reg;
            out_ok_reg     <= ok_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.mean_change  = out_mean_reg;
    assign rsp.mean_valid   = out_mvalid_reg;
    assign rsp.index_ok     = out_ok_reg;

endmodule

[sv/psvu_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvu_store
// Position, velocity and personal best memories, registered read.
// ----------------------------------------------------------------------------
module psvu_store
    import psvu_pkg::*;
#(
    parameter int DIM_MAX = DimMaxDefault,
    parameter int AddrW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1
) (
    input  logic                         clk,
    input  logic [AddrW-1:0]             addr,
    input  store_wr_t                    wr,
    input  logic signed [CoordWidth-1:0] pos_wdata,
    input  logic signed [CoordWidth-1:0] vel_wdata,
    output logic signed [CoordWidth-1:0] pos_rd,
    output logic signed [CoordWidth-1:0] vel_rd,
    output logic signed [CoordWidth-1:0] pb_rd
);

    logic signed [CoordWidth-1:0] pos_mem [DIM_MAX];
    logic signed [CoordWidth-1:0] vel_mem [DIM_MAX];
    logic signed [CoordWidth-1:0] pb_mem  [DIM_MAX];

    always_ff @(posedge clk)
    begin
        if (wr.pos_we)
            pos_mem[addr] <= pos_wdata;
        pos_rd <= pos_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.vel_we)
            vel_mem[addr] <= vel_wdata;
        vel_rd <= vel_mem[addr];
    end

    // personal best only ever takes the loaded position
    always_ff @(posedge clk)
    begin
        if (wr.pb_we)
            pb_mem[addr] <= pos_wdata;
        pb_rd <= pb_mem[addr];
    end

endmodule

[sv/psvu_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvu_mul
// Shared signed-by-unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module psvu_mul
    import psvu_pkg::*;
(
    input  logic                    clk,
    input  logic signed [MulAW-1:0] a,
    input  logic [MulBW-1:0]        b,
    output logic signed [ProdW-1:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * $signed({1'b0, b});
    end

endmodule

[sv/psvu_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psvu_div
    import psvu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SumW-1:0]   dividend,
    input  logic [DimsW-1:0]  divisor,
    output div_stat_t         stat,
    output logic [SumW-1:0]   quotient
);

    localparam int CountW = $clog2(SumW + 1);

    logic [SumW-1:0]   q_reg;
    logic [DimsW-1:0]  rem_reg;
    logic [CountW-1:0] count_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DimsW:0]    trial;
    logic              ge;

    assign trial = {rem_reg, q_reg[SumW-1]};
    assign ge = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CountW'(SumW - 1);
            end
            else if (busy_reg)
            begin
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[SumW-2:0], ge};
            rem_reg <= ge ? DimsW'(trial - {1'b0, divisor}) : trial[DimsW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = q_reg;

endmodule

[tb/psvu_velocity_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvu_velocity_checker
// Watches the request, result and register ports of the particle velocity
// update block. Keeps its own copy of the particle coordinates, coefficients
// and change sum, predicts the result of every accepted request and compares
// each returned transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module psvu_velocity_checker
    import psvu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    psvu_req_if                  req,
    psvu_rsp_if                  rsp,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   checked,
    output int                   sweep_means
);

    localparam int     DimLimit = DimMaxDefault;
    localparam longint CoordHi  = (longint'(1) <<< (CoordWidth - 1)) - 1;
    localparam longint CoordLo  = -CoordHi - 1;
    localparam longint SumHi    = (longint'(1) <<< SumW) - 1;
    localparam longint MeanHi   = (longint'(1) <<< MeanW) - 1;

    typedef struct packed {
        logic signed [CoordWidth-1:0] value;
        logic [MeanW-1:0]             mean;
        logic                         mean_valid;
        logic                         index_ok;
    } particle_result_t;

    logic signed [CoordWidth-1:0] position_mem [DimLimit];
    logic signed [CoordWidth-1:0] velocity_mem [DimLimit];
    logic signed [CoordWidth-1:0] best_mem [DimLimit];
    logic [SumW-1:0]              change_total;
    logic [CoefW-1:0]             inertia_w;
    logic [CoefW-1:0]             pull_g;
    logic [CoefW-1:0]             pull_l;
    logic [DimsW-1:0]             dim_count;
    particle_result_t             expected_results [$];

    initial
    begin
        mismatches  = 0;
        pending     = 0;
        checked     = 0;
        sweep_means = 0;
    end

    // floor(a * k / 2^sh); arithmetic shift rounds towards minus infinity
    function automatic longint floor_scale(input longint a, input longint k, input int sh);
        return (a * k) >>> sh;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > CoordHi)
            return CoordHi;
        if (v < CoordLo)
            return CoordLo;
        return v;
    endfunction

    function automatic particle_result_t predict_particle_step(
        input req_kind_t                    kind,
        input logic [IndexW-1:0]            idx,
        input logic signed [CoordWidth-1:0] coord,
        input logic signed [CoordWidth-1:0] vel,
        input logic [FracW-1:0]             r_g,
        input logic [FracW-1:0]             r_l
    );
        particle_result_t res;
        int               lim;
        longint           x;
        longint           v;
        longint           pull_a;
        longint           pull_b;
        longint           new_v;
        longint           delta;
        longint           total;
        logic [31:0]      rc_g;
        logic [31:0]      rc_l;
        res = '0;
        lim = (dim_count < DimLimit) ? int'(dim_count) : DimLimit;
        if (int'(idx) >= lim)
            return res;
        res.index_ok = 1'b1;
        case (kind)
            REQ_LOAD:
            begin
                position_mem[idx] = coord;
                best_mem[idx]     = coord;
                velocity_mem[idx] = vel;
            end
            REQ_VEL:
            begin
                x      = position_mem[idx];
                v      = velocity_mem[idx];
                rc_g   = 32'(r_g) * 32'(pull_g);
                rc_l   = 32'(r_l) * 32'(pull_l);
                pull_a = floor_scale(longint'(coord) - x, longint'(rc_g), PullShift);
                pull_b = floor_scale(longint'(best_mem[idx]) - x, longint'(rc_l), PullShift);
                new_v  = clamp_coord(floor_scale(v + pull_a + pull_b, longint'(inertia_w),
                                                 InertiaShift));
                delta  = v - new_v;
                if (delta < 0)
                    delta = -delta;
                total = longint'(change_total) + delta;
                if (total > SumHi)
                    change_total = SumW'(SumHi);
                else
                    change_total = SumW'(total);
                velocity_mem[idx] = CoordWidth'(new_v);
                res.value         = CoordWidth'(new_v);
                if (int'(idx) == lim - 1)
                begin
                    total = longint'(change_total) / lim;
                    if (total > MeanHi)
                        res.mean = MeanW'(MeanHi);
                    else
                        res.mean = MeanW'(total);
                    res.mean_valid = 1'b1;
                    change_total   = '0;
                end
            end
            REQ_POS:
            begin
                position_mem[idx] = CoordWidth'(clamp_coord(longint'(position_mem[idx])
                                                + longint'(velocity_mem[idx])));
                res.value = position_mem[idx];
            end
            default:
                res.value = position_mem[idx];
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input particle_result_t want,
                                   input particle_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected value=%0d mean=%0d mean_valid=%0b index_ok=%0b,",
                     $time, what, want.value, want.mean, want.mean_valid, want.index_ok,
                     " got value=%0d mean=%0d mean_valid=%0b index_ok=%0b",
                     got.value, got.mean, got.mean_valid, got.index_ok);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        particle_result_t got;
        particle_result_t want;
        if (!rst_n)
        begin
            inertia_w    = InertiaReset;
            pull_g       = PullReset;
            pull_l       = PullReset;
            dim_count    = DimsReset;
            change_total = '0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CfgInertia:    inertia_w = cfg_data;
                    CfgPullGlobal: pull_g    = cfg_data;
                    CfgPullLocal:  pull_l    = cfg_data;
                    CfgDims:       dim_count = cfg_data[DimsW-1:0];
                    default:       ;
                endcase
            end
            if (req.valid && req.ready)
                expected_results.push_back(predict_particle_step(
                    req_kind_t'(req.req_type), req.elem_index, req.coord_value,
                    req.vel_value, req.rand_global, req.rand_local));
            if (rsp.valid && rsp.ready)
            begin
                got.value      = rsp.result_value;
                got.mean       = rsp.mean_change;
                got.mean_valid = rsp.mean_valid;
                got.index_ok   = rsp.index_ok;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing pending", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.mean_valid)
                        sweep_means++;
                    if (got.value !== want.value || got.mean !== want.mean
                        || got.mean_valid !== want.mean_valid
                        || got.index_ok !== want.index_ok)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

[tb/tb_particle_swarm_velocity_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_swarm_velocity_update
// Drives loads, velocity and position updates and reads into the block under
// a range of coefficient and dimension settings, with bursty requests and a
// stalling result receiver. The checker alongside predicts and compares every
// result; this module generates stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_particle_swarm_velocity_update;
    import psvu_pkg::*;

    localparam int ItemsTarget   = 1150;
    localparam int WatchdogLimit = 5000;
    localparam int HoldCycles    = 400;
    localparam int DrainCycles   = 60;
    localparam int SwingCount    = 136;
    localparam int DimLimit      = DimMaxDefault;

    localparam logic signed [CoordWidth-1:0] CoordTop    = {1'b0, {(CoordWidth-1){1'b1}}};
    localparam logic signed [CoordWidth-1:0] CoordBottom = {1'b1, {(CoordWidth-1){1'b0}}};
    localparam logic [FracW-1:0]             FracTop     = '1;
    localparam logic [CoefW-1:0]             CoefTop     = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;
    int                   mismatches;
    int                   pending;
    int                   checked;
    int                   sweep_means;
    int                   requests_sent;
    int                   settings_used;
    int                   idle_cycles;
    int                   burst_left;
    logic [DimsW-1:0]     dims_now;
    bit                   loaded [DimLimit];
    bit                   hold_rsp;

    psvu_req_if req ();
    psvu_rsp_if rsp ();

    particle_swarm_velocity_update i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psvu_velocity_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .sweep_means (sweep_means)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("particle_swarm_velocity_update test failed");
            $finish;
        end
    end

    // result receiver: stall patterns of its own, plus one long hold-off
    initial
    begin : receiver
        int mode;
        int mode_left;
        int tick;
        bit hold_done;
        rsp.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp && !hold_done)
            begin
                rsp.ready = 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       rsp.ready = 1'b1;
                1:       rsp.ready = ($urandom_range(0, 3) != 0);
                2:       rsp.ready = ($urandom_range(0, 3) == 0);
                default: rsp.ready = (tick % 3 != 0);
            endcase
        end
    end

    function automatic int index_limit();
        return (dims_now < DimLimit) ? int'(dims_now) : DimLimit;
    endfunction

    function automatic logic signed [CoordWidth-1:0] pick_coord();
        logic signed [CoordWidth-1:0] c;
        case ($urandom_range(0, 7))
            0: c = CoordTop;
            1: c = CoordBottom;
            2: c = '0;
            3, 4, 5:
            begin
                c = CoordWidth'($urandom_range(0, 8191));
                c = c - 24'sd4096;
            end
            default: c = CoordWidth'($urandom());
        endcase
        return c;
    endfunction

    function automatic logic [FracW-1:0] pick_frac();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FracTop;
            default: return FracW'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CoefW-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CoefTop;
            2:       return InertiaReset;
            3:       return CoefW'($urandom_range(0, 8191));
            default: return CoefW'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [DimsW-1:0] pick_dims();
        case ($urandom_range(0, 11))
            0:       return 7'd64;
            1:       return DimsW'($urandom_range(1, 64));
            2:       return 7'd0;
            3:       return DimsW'($urandom_range(65, 127));
            default: return DimsW'($urandom_range(1, 8));
        endcase
    endfunction

    // one request transaction; a request to an unloaded in-range entry is sent as a load instead
    task automatic send_req(input req_kind_t kind, input int idx,
                            input logic signed [CoordWidth-1:0] coord,
                            input logic signed [CoordWidth-1:0] vel,
                            input logic [FracW-1:0] r_g, input logic [FracW-1:0] r_l);
        req_kind_t k;
        int        gap;
        k = kind;
        if (k != REQ_LOAD && idx < index_limit() && !loaded[idx])
            k = REQ_LOAD;
        if (k == REQ_LOAD && idx < index_limit())
            loaded[idx] = 1'b1;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 7))
                0:       gap = $urandom_range(10, 30);
                1:       gap = 0;
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0)
            begin
                req.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        req.req_type    = k;
        req.elem_index  = IndexW'(idx);
        req.coord_value = coord;
        req.vel_value   = vel;
        req.rand_global = r_g;
        req.rand_local  = r_l;
        req.valid       = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        requests_sent++;
        @(negedge clk);
    endtask

    // random traffic stops once the item budget is spent
    task automatic send_any(input req_kind_t kind, input int idx);
        if (requests_sent < ItemsTarget)
            send_req(kind, idx, pick_coord(), pick_coord(), pick_frac(), pick_frac());
    endtask

    task automatic wait_idle();
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [CoefW-1:0] w, input logic [CoefW-1:0] c_g,
                             input logic [CoefW-1:0] c_l, input logic [DimsW-1:0] d);
        wait_idle();
        write_reg(CfgInertia, w);
        write_reg(CfgPullGlobal, c_g);
        write_reg(CfgPullLocal, c_l);
        write_reg(CfgDims, CfgDataW'(d));
        dims_now = d;
        settings_used++;
    endtask

    task automatic directed_part();
        // reset coefficients, all 64 coordinates in use
        send_req(REQ_LOAD, 0, CoordTop, CoordBottom, '0, '0);
        send_req(REQ_LOAD, 63, CoordBottom, CoordTop, '0, '0);
        send_req(REQ_LOAD, 1, '0, '0, FracTop, FracTop);
        send_req(REQ_LOAD, 2, CoordTop, CoordTop, '0, '0);
        send_req(REQ_LOAD, 3, CoordBottom, CoordBottom, '0, '0);
        send_req(REQ_READ, 0, '0, '0, '0, '0);
        send_req(REQ_READ, 63, CoordTop, CoordTop, FracTop, FracTop);
        send_req(REQ_POS, 0, '0, '0, '0, '0);
        send_req(REQ_POS, 2, '0, '0, '0, '0);
        send_req(REQ_POS, 3, '0, '0, '0, '0);
        send_req(REQ_VEL, 1, CoordTop, '0, FracTop, FracTop);
        send_req(REQ_VEL, 0, CoordBottom, '0, '0, FracTop);
        send_req(REQ_VEL, 63, CoordTop, '0, FracTop, '0);
        // extreme coefficients, short vector, out-of-range indices
        configure(CoefTop, CoefTop, '0, 7'd4);
        send_req(REQ_VEL, 0, CoordTop, '0, FracTop, FracTop);
        send_req(REQ_VEL, 3, CoordBottom, '0, FracTop, FracTop);
        send_req(REQ_READ, 4, '0, '0, '0, '0);
        send_req(REQ_LOAD, 40, CoordTop, CoordTop, '0, '0);
        send_req(REQ_VEL, 63, CoordTop, '0, FracTop, FracTop);
        send_req(REQ_POS, 5, '0, '0, '0, '0);
        // zero dimensions: nothing is in range
        configure('0, '0, CoefTop, 7'd0);
        send_req(REQ_LOAD, 0, CoordTop, CoordTop, '0, '0);
        send_req(REQ_READ, 0, '0, '0, '0, '0);
        // dims above the store depth is limited to it
        configure(16'd2048, 16'd1, InertiaReset, 7'd100);
        send_req(REQ_VEL, 63, pick_coord(), '0, pick_frac(), pick_frac());
        send_req(REQ_POS, 1, '0, '0, '0, '0);
        send_req(REQ_READ, 2, '0, '0, '0, '0);
        // single coordinate: every velocity update closes a sweep
        configure(InertiaReset, PullReset, PullReset, 7'd1);
        send_req(REQ_VEL, 0, CoordBottom, '0, FracTop, FracTop);
        send_req(REQ_VEL, 0, CoordTop, '0, FracTop, '0);
    endtask

    // full-scale velocity swings to saturate the change sum and the mean
    task automatic swing_phase();
        int i;
        configure(CoefTop, CoefTop, CoefTop, 7'd2);
        send_req(REQ_LOAD, 0, '0, CoordBottom, '0, '0);
        send_req(REQ_LOAD, 1, '0, '0, '0, '0);
        for (i = 0; i < SwingCount; i++)
            send_req(REQ_VEL, 0, i[0] ? CoordBottom : CoordTop, pick_coord(),
                     FracTop, pick_frac());
        send_req(REQ_VEL, 1, pick_coord(), pick_coord(), pick_frac(), pick_frac());
    endtask

    task automatic random_phase(input bit with_hold);
        int lim;
        int i;
        int idx;
        configure(pick_coef(), pick_coef(), pick_coef(), pick_dims());
        lim = index_limit();
        if (with_hold)
        begin
            hold_rsp = 1'b1;
            repeat (12) send_any(req_kind_t'($urandom_range(0, 3)), $urandom_range(0, 63));
        end
        repeat ($urandom_range(2, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    for (i = 0; i < lim; i++)
                        send_any(REQ_LOAD, i);
                2, 3, 4, 5:
                    for (i = 0; i < lim; i++)
                        send_any(REQ_VEL, i);
                6:
                    for (i = 0; i < lim; i++)
                        send_any(REQ_POS, i);
                7:
                    for (i = 0; i < lim; i++)
                        send_any(REQ_READ, i);
                default:
                    repeat ($urandom_range(3, 10))
                    begin
                        idx = (lim > 0 && $urandom_range(0, 1) == 1)
                              ? $urandom_range(0, lim - 1) : $urandom_range(0, DimLimit - 1);
                        send_any(req_kind_t'($urandom_range(0, 3)), idx);
                    end
            endcase
        end
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        req.valid       = 1'b0;
        req.req_type    = REQ_LOAD;
        req.elem_index  = '0;
        req.coord_value = '0;
        req.vel_value   = '0;
        req.rand_global = '0;
        req.rand_local  = '0;
        dims_now        = DimsReset;
        hold_rsp        = 1'b0;
        burst_left      = 0;
        requests_sent   = 0;
        settings_used   = 1;
        phase           = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        directed_part();
        while (requests_sent < ItemsTarget)
        begin
            if (phase == 3)
                swing_phase();
            else
                random_phase(phase == 1);
            phase++;
        end
        wait_idle();
        repeat (DrainCycles) @(posedge clk);
        $display("Covered %0d requests under %0d register settings: %0d results checked,",
                 requests_sent, settings_used, checked);
        $display("%0d of them closing a velocity sweep with a mean change.", sweep_means);
        if (mismatches == 0 && pending == 0)
            $display("particle_swarm_velocity_update test passed");
        else
            $display("particle_swarm_velocity_update test failed");
        $finish;
    end

endmodule

[filelist.f]
sv/psvu_pkg.sv
sv/psvu_req_if.sv
sv/psvu_rsp_if.sv
sv/psvu_store.sv
sv/psvu_mul.sv
sv/psvu_div.sv
sv/particle_swarm_velocity_update.sv
tb/psvu_velocity_checker.sv
tb/tb_particle_swarm_velocity_update.sv
